// File: hw/rtl/evad_pkg.sv
package evad_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CFG_W    = 16;
   localparam int RMS_W    = 16;
   localparam int EVENT_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam int SQRT_STEPS = RMS_W;

   localparam int DEF_MAX_CHUNK_SAMPLES = 8192;

   localparam logic [CFG_W-1:0] RST_RMS_THRESHOLD = 16'd500;
   localparam logic [CFG_W-1:0] RST_HANGOVER_MS   = 16'd800;
   localparam logic [CFG_W-1:0] RST_MAX_SPEECH_MS = 16'd15000;

   localparam logic [CSR_IDX_W-1:0] CSR_RMS_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HANGOVER_MS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEECH_MS = 2'd2;

   typedef enum logic [EVENT_W-1:0] {
      EVT_NONE  = 2'd0,
      EVT_START = 2'd1,
      EVT_END   = 2'd2
   } evad_event_type;

   typedef struct packed {
      logic sample_load;
      logic tick;
      logic add;
      logic div_step;
      logic sqrt_init;
      logic sqrt_step;
      logic decide;
   } evad_cmd_type;

   typedef struct packed {
      logic chunk_end;
   } evad_status_type;

endpackage

// File: hw/rtl/energy_voice_activity_detector.sv
// Energy voice activity detector. Sample items (req_mode 0) are squared and
// summed per chunk; the last sample of a chunk (req_chunk_last, or the sample
// that fills MAX_CHUNK_SAMPLES) produces one result with the chunk's integer
// RMS, the speech state and a start/end event. Tick items (req_mode 1) advance
// the millisecond counters and produce no result. A sample is squared, then
// accumulated; for a chunk's last sample a one-bit-per-cycle restoring
// divider then forms the mean, and a two-bits-per-cycle digit root unit
// runs 16 steps; the result then waits for the output register to be free.
// Registers are written through the csr_ port: index 0 RMS threshold,
// 1 hangover in ms, 2 maximum speech in ms; write only while no chunk
// decision is pending.
module energy_voice_activity_detector #(
   parameter int MAX_CHUNK_SAMPLES = evad_pkg::DEF_MAX_CHUNK_SAMPLES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic signed [evad_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_chunk_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [evad_pkg::RMS_W-1:0]           rsp_chunk_rms,
   output logic                                 rsp_speech_active,
   output logic [evad_pkg::EVENT_W-1:0]         rsp_speech_event,
   input  logic                                 csr_wr_en,
   input  logic [evad_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [evad_pkg::CFG_W-1:0]           csr_wr_data
);
   import evad_pkg::*;

   evad_cmd_type    cmd;
   evad_status_type status;

   evad_ctrl #(
      .MAX_CHUNK_SAMPLES(MAX_CHUNK_SAMPLES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   evad_dp #(
      .MAX_CHUNK_SAMPLES(MAX_CHUNK_SAMPLES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_sample        (req_sample),
      .req_chunk_last    (req_chunk_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_chunk_rms     (rsp_chunk_rms),
      .rsp_speech_active (rsp_speech_active),
      .rsp_speech_event  (rsp_speech_event)
   );

endmodule

// File: hw/rtl/evad_ctrl.sv
module evad_ctrl #(
   parameter int MAX_CHUNK_SAMPLES = evad_pkg::DEF_MAX_CHUNK_SAMPLES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_mode,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output evad_pkg::evad_cmd_type  cmd,
   input  evad_pkg::evad_status_type status
);
   import evad_pkg::*;

   localparam int SUM_W  = 2 * SAMPLE_W - 1 + $clog2(MAX_CHUNK_SAMPLES);
   localparam int STEP_W = $clog2(SUM_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_DIV,
      ST_SQINIT,
      ST_SQRT,
      ST_DONE
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              rsp_valid_ff;
   logic              slot_free;
   logic              div_last;
   logic              sqrt_last;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign div_last  = (step_ff == STEP_W'(SUM_W - 1));
   assign sqrt_last = (step_ff == STEP_W'(SQRT_STEPS - 1));

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.tick        = req_valid && req_mode;
            cmd.sample_load = req_valid && !req_mode;
         end
         ST_ADD:    cmd.add       = 1'b1;
         ST_DIV:    cmd.div_step  = 1'b1;
         ST_SQINIT: cmd.sqrt_init = 1'b1;
         ST_SQRT:   cmd.sqrt_step = 1'b1;
         ST_DONE:   cmd.decide    = slot_free;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // raise the result as the decision moves into the output register,
         // drop it once its transfer completes
         if (state_ff == ST_DONE && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && !req_mode) begin
                  state_ff <= ST_ADD;
               end
            end
            ST_ADD: begin
               step_ff <= '0;
               if (status.chunk_end) begin
                  state_ff <= ST_DIV;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_DIV: begin
               if (div_last) begin
                  step_ff  <= '0;
                  state_ff <= ST_SQINIT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_SQINIT: begin
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               if (sqrt_last) begin
                  step_ff  <= '0;
                  state_ff <= ST_DONE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_DONE: begin
               // hold until the output register is free
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the decision state");

   a_div_to_sqrt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_last) |=> (state_ff == ST_SQINIT))
      else $error("divider did not hand over to the root unit");

   a_step_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV && state_ff != ST_SQRT) |-> (step_ff == '0))
      else $error("step counter not cleared outside iteration");

endmodule

// File: hw/rtl/evad_dp.sv
module evad_dp #(
   parameter int MAX_CHUNK_SAMPLES = evad_pkg::DEF_MAX_CHUNK_SAMPLES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [evad_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                              req_chunk_last,
   input  logic                              csr_wr_en,
   input  logic [evad_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [evad_pkg::CFG_W-1:0]        csr_wr_data,
   input  evad_pkg::evad_cmd_type            cmd,
   output evad_pkg::evad_status_type         status,
   output logic [evad_pkg::RMS_W-1:0]        rsp_chunk_rms,
   output logic                              rsp_speech_active,
   output logic [evad_pkg::EVENT_W-1:0]      rsp_speech_event
);
   import evad_pkg::*;

   localparam int SQ_W   = 2 * SAMPLE_W - 1;
   localparam int SUM_W  = SQ_W + $clog2(MAX_CHUNK_SAMPLES);
   localparam int CNT_W  = $clog2(MAX_CHUNK_SAMPLES + 1);
   localparam int THR2_W = 2 * CFG_W;
   localparam int PROD_W = THR2_W + CNT_W;
   localparam int X_W    = 2 * RMS_W;
   localparam int REM_W  = RMS_W + 2;

   // configuration
   logic [CFG_W-1:0] thr_ff, hang_ff, maxsp_ff;

   // accumulation
   logic [SQ_W-1:0]  sq_ff;
   logic             last_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic [SUM_W-1:0] total_in;
   logic signed [2*SAMPLE_W-1:0] samp_prod;

   // divider and threshold test
   logic [SUM_W-1:0]  dq_ff, tot_ff;
   logic [CNT_W-1:0]  n_ff, div_rem_ff, div_rem_in;
   logic [CNT_W:0]    div_trial, div_diff;
   logic              div_ge;
   logic [THR2_W-1:0] thr2_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              voiced_ff;

   // root
   logic [X_W-1:0]   x_ff;
   logic [REM_W-1:0] sq_rem_ff, sq_rem_sh, sq_trial, sq_rem_in;
   logic [RMS_W-1:0] root_ff;
   logic             sq_ge;

   // speech state
   logic             speaking_ff, speaking_in;
   logic [CFG_W-1:0] msv_ff, msv_in, mss_ff, mss_in;
   evad_event_type   event_in;

   logic [RMS_W-1:0]   rsp_rms_ff;
   logic               rsp_active_ff;
   evad_event_type     rsp_event_ff;

   assign samp_prod = (2*SAMPLE_W)'(req_sample) * (2*SAMPLE_W)'(req_sample);
   assign cnt_in    = cnt_ff + 1'b1;
   assign total_in  = sum_ff + SUM_W'(sq_ff);

   // the chunk also closes when it reaches the sample limit
   assign status.chunk_end = last_ff || (cnt_in == CNT_W'(MAX_CHUNK_SAMPLES));

   assign div_trial  = {div_rem_ff, dq_ff[SUM_W-1]};
   assign div_ge     = (div_trial >= {1'b0, n_ff});
   assign div_diff   = div_trial - {1'b0, n_ff};
   assign div_rem_in = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];

   assign sq_rem_sh = {sq_rem_ff[REM_W-3:0], x_ff[X_W-1 -: 2]};
   assign sq_trial  = {root_ff, 2'b01};
   assign sq_ge     = (sq_rem_sh >= sq_trial);
   assign sq_rem_in = sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;

   always_comb begin
      speaking_in = speaking_ff;
      msv_in      = msv_ff;
      mss_in      = mss_ff;
      event_in    = EVT_NONE;
      if (voiced_ff) begin
         msv_in = '0;
         if (!speaking_ff) begin
            speaking_in = 1'b1;
            mss_in      = '0;
            event_in    = EVT_START;
         end
      end else if (speaking_ff && (msv_ff >= hang_ff)) begin
         speaking_in = 1'b0;
         event_in    = EVT_END;
      end
      // forced end on overlong speech; a start cut at once reports nothing
      if (speaking_in && (mss_in >= maxsp_ff)) begin
         speaking_in = 1'b0;
         event_in    = (event_in == EVT_START) ? EVT_NONE : EVT_END;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= RST_RMS_THRESHOLD;
         hang_ff     <= RST_HANGOVER_MS;
         maxsp_ff    <= RST_MAX_SPEECH_MS;
         sum_ff      <= '0;
         cnt_ff      <= '0;
         speaking_ff <= 1'b0;
         msv_ff      <= '0;
         mss_ff      <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RMS_THRESHOLD: thr_ff   <= csr_wr_data;
               CSR_HANGOVER_MS:   hang_ff  <= csr_wr_data;
               CSR_MAX_SPEECH_MS: maxsp_ff <= csr_wr_data;
               default: ;
            endcase
         end
         if (cmd.add) begin
            if (status.chunk_end) begin
               sum_ff <= '0;
               cnt_ff <= '0;
            end else begin
               sum_ff <= total_in;
               cnt_ff <= cnt_in;
            end
         end
         if (cmd.tick) begin
            // saturate at all ones
            if (msv_ff != '1) msv_ff <= msv_ff + 1'b1;
            if (mss_ff != '1) mss_ff <= mss_ff + 1'b1;
         end else if (cmd.decide) begin
            speaking_ff <= speaking_in;
            msv_ff      <= msv_in;
            mss_ff      <= mss_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sample_load) begin
         sq_ff   <= samp_prod[SQ_W-1:0];
         last_ff <= req_chunk_last;
      end
      if (cmd.add && status.chunk_end) begin
         dq_ff      <= total_in;
         tot_ff     <= total_in;
         n_ff       <= cnt_in;
         div_rem_ff <= '0;
         thr2_ff    <= THR2_W'(thr_ff) * THR2_W'(thr_ff);
      end
      if (cmd.div_step) begin
         div_rem_ff <= div_rem_in;
         dq_ff      <= {dq_ff[SUM_W-2:0], div_ge};
      end
      // threshold test settles through prod_ff and then voiced_ff while the divider runs
      prod_ff   <= PROD_W'(thr2_ff) * PROD_W'(n_ff);
      voiced_ff <= (PROD_W'(tot_ff) >= prod_ff);
      if (cmd.sqrt_init) begin
         x_ff      <= X_W'(dq_ff[SQ_W-1:0]);
         sq_rem_ff <= '0;
         root_ff   <= '0;
      end
      if (cmd.sqrt_step) begin
         x_ff      <= {x_ff[X_W-3:0], 2'b00};
         sq_rem_ff <= sq_rem_in;
         root_ff   <= {root_ff[RMS_W-2:0], sq_ge};
      end
      if (cmd.decide) begin
         rsp_rms_ff    <= root_ff;
         rsp_active_ff <= speaking_in;
         rsp_event_ff  <= event_in;
      end
   end

   assign rsp_chunk_rms     = rsp_rms_ff;
   assign rsp_speech_active = rsp_active_ff;
   assign rsp_speech_event  = rsp_event_ff;

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (div_rem_ff < n_ff))
      else $error("divider remainder not below divisor");

   a_root_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.sqrt_step |-> (sq_rem_ff <= {1'b0, root_ff, 1'b0}))
      else $error("root remainder exceeds twice the partial root");

   a_start_is_active: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> !(rsp_event_ff == EVT_START && !rsp_active_ff))
      else $error("speech start reported while inactive");

endmodule
